@@ hw/rtl/arpc_pkg.sv @@
// Package for the ARP responder and address cache.
// Holds the sequencer states, operation and status codes, protocol constants and field widths.
// No dependencies; used by arp_responder_cache.
`default_nettype none

package arpc_pkg;

    // Default number of cache entries.
    localparam int unsigned CACHE_ENTRIES_DEF = 16;

    // Configuration port address width (registers at byte addresses 0, 8 and 16).
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 64;

    // Stream widths.
    localparam int unsigned S_TDATA_W = 192;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 184;
    localparam int unsigned M_TUSER_W = 3;

    localparam int unsigned MAC_W = 48;
    localparam int unsigned IP_W  = 32;

    // Protocol constants.
    localparam logic [10:0] MIN_LEN     = 11'd28;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN      = 8'd6;
    localparam logic [7:0]  PROTO_LEN   = 8'd4;
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;
    localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
    localparam int unsigned MCAST_BIT   = 40;

    // Register indexes on the configuration port (paddr[4:3]).
    typedef enum logic [1:0] {
        REG_LOCAL_MAC      = 2'd0,
        REG_LOCAL_IP       = 2'd1,
        REG_LOCAL_IP_VALID = 2'd2,
        REG_NONE           = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_REQUEST = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DROPPED  = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_REPLIED  = 3'd2,
        ST_REQ_SENT = 3'd3,
        ST_REQ_REF  = 3'd4,
        ST_HIT      = 3'd5,
        ST_MISS     = 3'd6,
        ST_CLEARED  = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        FOP_NONE    = 2'd0,
        FOP_REQUEST = 2'd1,
        FOP_REPLY   = 2'd2
    } t_fop;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE,
        S_OUT
    } t_state;

endpackage : arpc_pkg

`default_nettype wire

@@ hw/rtl/arp_responder_cache.sv @@
// ARP responder with a small IPv4-to-MAC address cache, top level.
// Depends on arpc_pkg for codes, constants and widths.
// Holds the sequencer, the cache memory, the configuration registers and the result register.
//
//  Channel   | Direction | Handshake                | Contents
//  ----------+-----------+--------------------------+-------------------------------------
//  s_axis    | in        | tvalid/tready            | one operation with a parsed ARP packet
//  m_axis    | out       | tvalid/tready            | one result per operation
//  APB       | in        | psel/penable, pready = 1 | local_mac, local_ip, local_ip_valid
//
// An item is taken in the idle state and checked in the check state; then follow a scan of the
// cache that reads one entry a cycle through the single, registered memory read port, a
// write-back step for a received packet, and the output state that loads the result.
// Requests, clears and dropped packets skip the scan.
// Reset clears the valid flag of every entry at once; the address and MAC storage is not cleared.
// The input is ready only while the sequencer is idle. A finished result waits in the output
// register, and a further item is taken meanwhile; it stalls in its last step until the
// result ahead has been taken.
`default_nettype none

module arp_responder_cache #(
    parameter int unsigned CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,

    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // From bit 0: frame_length(11), hw_type(16), proto_type(16), hw_addr_len(8),
    // proto_addr_len(8), arp_opcode(16), src_mac(48), sender_ip(32), target_ip(32), zeros.
    input  wire logic [arpc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // From bit 0: operation(2).
    input  wire logic [arpc_pkg::S_TUSER_W-1:0]   s_axis_tuser,

    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // From bit 0: cache_stored(1), frame_dest_mac(48), frame_opcode(2), frame_target_mac(48),
    // frame_target_ip(32), lookup_mac(48), zeros.
    output logic [arpc_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // From bit 0: status(3).
    output logic [arpc_pkg::M_TUSER_W-1:0]        m_axis_tuser,

    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [arpc_pkg::APB_AW-1:0]      paddr,
    input  wire logic [arpc_pkg::APB_DW-1:0]      pwdata,
    output logic [arpc_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);

    localparam int unsigned IW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned MW   = arpc_pkg::MAC_W;
    localparam int unsigned PW   = arpc_pkg::IP_W;
    localparam int unsigned EW   = MW + PW;
    localparam logic [IW-1:0] LAST = IW'(CACHE_ENTRIES - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MW-1:0] r_local_mac;
    logic [PW-1:0] r_local_ip;
    logic          r_local_ip_valid;
    logic          cfg_wr;
    arpc_pkg::t_reg cfg_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_reg = arpc_pkg::t_reg'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac      <= '0;
            r_local_ip       <= '0;
            r_local_ip_valid <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_reg)
                arpc_pkg::REG_LOCAL_MAC:      r_local_mac      <= pwdata[MW-1:0];
                arpc_pkg::REG_LOCAL_IP:       r_local_ip       <= pwdata[PW-1:0];
                arpc_pkg::REG_LOCAL_IP_VALID: r_local_ip_valid <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg)
            arpc_pkg::REG_LOCAL_MAC:      prdata = {16'h0, r_local_mac};
            arpc_pkg::REG_LOCAL_IP:       prdata = {32'h0, r_local_ip};
            arpc_pkg::REG_LOCAL_IP_VALID: prdata = {63'h0, r_local_ip_valid};
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Latched item
    // ------------------------------------------------------------------
    arpc_pkg::t_op r_op;
    logic [10:0]   r_len;
    logic [15:0]   r_htype;
    logic [15:0]   r_ptype;
    logic [7:0]    r_hlen;
    logic [7:0]    r_plen;
    logic [15:0]   r_opcode;
    logic [MW-1:0] r_smac;
    logic [PW-1:0] r_sip;
    logic [PW-1:0] r_tip;

    // Sequencer state and scan bookkeeping.
    arpc_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_key;
    logic          r_drop;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [MW-1:0] r_hit_mac;
    logic          r_free_found;
    logic [IW-1:0] r_free_idx;
    logic          r_stored;

    // Cache storage: valid flags in flip-flops, address pairs in a memory.
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [EW-1:0]            mem [CACHE_ENTRIES];
    logic [PW-1:0]            r_rd_ip;
    logic [MW-1:0]            r_rd_mac;

    // Result register.
    logic                          r_m_valid;
    logic [arpc_pkg::M_TDATA_W-1:0] r_m_data;
    logic [arpc_pkg::M_TUSER_W-1:0] r_m_user;

    logic in_acc;
    logic out_load;
    logic drop_now;
    logic hit_now;
    logic scan_done;
    logic mem_we;
    logic [IW-1:0] mem_waddr;

    arpc_pkg::t_status res_status;
    logic              res_stored;
    logic [MW-1:0]     res_dest_mac;
    arpc_pkg::t_fop    res_fop;
    logic [MW-1:0]     res_tmac;
    logic [PW-1:0]     res_tip;
    logic [MW-1:0]     res_lmac;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Validity checks on a received packet; any failure drops it untouched.
    assign drop_now = !r_local_ip_valid
                   || (r_len < arpc_pkg::MIN_LEN)
                   || (r_htype != arpc_pkg::HW_ETHERNET)
                   || (r_ptype != arpc_pkg::PROTO_IPV4)
                   || (r_hlen != arpc_pkg::HW_LEN)
                   || (r_plen != arpc_pkg::PROTO_LEN)
                   || ((r_opcode != arpc_pkg::OPC_REQUEST) && (r_opcode != arpc_pkg::OPC_REPLY))
                   || (r_smac == '0)
                   || r_smac[arpc_pkg::MCAST_BIT]
                   || (r_sip == '0);

    // The one comparator of the scan: the entry read last cycle against the search key.
    assign hit_now   = r_cmp_vld && r_valid[r_cmp_idx] && (r_rd_ip == r_key);
    assign scan_done = r_cmp_vld && (hit_now || (r_cmp_idx == LAST));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arpc_pkg::S_IDLE: begin
                if (in_acc) n_state = arpc_pkg::S_CHECK;
            end
            arpc_pkg::S_CHECK: begin
                unique case (r_op)
                    arpc_pkg::OP_RECEIVE: n_state = drop_now ? arpc_pkg::S_OUT : arpc_pkg::S_SCAN;
                    arpc_pkg::OP_LOOKUP:  n_state = arpc_pkg::S_SCAN;
                    default:              n_state = arpc_pkg::S_OUT;
                endcase
            end
            arpc_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = (r_op == arpc_pkg::OP_RECEIVE) ? arpc_pkg::S_WRITE
                                                             : arpc_pkg::S_OUT;
                end
            end
            arpc_pkg::S_WRITE: n_state = arpc_pkg::S_OUT;
            arpc_pkg::S_OUT: begin
                if (out_load) n_state = arpc_pkg::S_IDLE;
            end
            default: n_state = arpc_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = (r_state == arpc_pkg::S_IDLE);
        out_load      = (r_state == arpc_pkg::S_OUT) && (!r_m_valid || m_axis_tready);
        mem_we        = (r_state == arpc_pkg::S_WRITE) && (r_hit || r_free_found);
        mem_waddr     = r_hit ? r_hit_idx : r_free_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Item capture, scan and write-back
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= arpc_pkg::t_op'(s_axis_tuser[1:0]);
            r_len    <= s_axis_tdata[10:0];
            r_htype  <= s_axis_tdata[26:11];
            r_ptype  <= s_axis_tdata[42:27];
            r_hlen   <= s_axis_tdata[50:43];
            r_plen   <= s_axis_tdata[58:51];
            r_opcode <= s_axis_tdata[74:59];
            r_smac   <= s_axis_tdata[122:75];
            r_sip    <= s_axis_tdata[154:123];
            r_tip    <= s_axis_tdata[186:155];
        end

        unique case (r_state)
            arpc_pkg::S_CHECK: begin
                r_drop       <= drop_now;
                r_key        <= (r_op == arpc_pkg::OP_RECEIVE) ? r_sip : r_tip;
                r_idx        <= '0;
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
                r_stored     <= 1'b0;
            end
            arpc_pkg::S_SCAN: begin
                if (r_idx != LAST) r_idx <= r_idx + 1'b1;
                if (hit_now) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_cmp_idx;
                    r_hit_mac <= r_rd_mac;
                end else if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
            end
            arpc_pkg::S_WRITE: begin
                r_stored <= r_hit || r_free_found;
            end
            default: ;
        endcase
    end

    // Compare stage valid flag; cleared whenever a scan is not under way.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= (r_state == arpc_pkg::S_SCAN) && !scan_done;
        end
        r_cmp_idx <= r_idx;
    end

    // Valid flags: cleared by reset or a clear operation, set when a free entry is filled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if ((r_state == arpc_pkg::S_CHECK) && (r_op == arpc_pkg::OP_CLEAR)) begin
            r_valid <= '0;
        end else if (mem_we && !r_hit) begin
            r_valid[mem_waddr] <= 1'b1;
        end
    end

    // Cache memory: one write port, one registered read port driven by the scan index.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= {r_sip, r_smac};
        end
        {r_rd_ip, r_rd_mac} <= mem[r_idx];
    end

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    always_comb begin
        res_status   = arpc_pkg::ST_DROPPED;
        res_stored   = 1'b0;
        res_dest_mac = '0;
        res_fop      = arpc_pkg::FOP_NONE;
        res_tmac     = '0;
        res_tip      = '0;
        res_lmac     = '0;
        unique case (r_op)
            arpc_pkg::OP_RECEIVE: begin
                if (!r_drop) begin
                    res_stored = r_stored;
                    // Only a request aimed at this station is answered.
                    if ((r_tip == r_local_ip) && (r_opcode == arpc_pkg::OPC_REQUEST)) begin
                        res_status   = arpc_pkg::ST_REPLIED;
                        res_dest_mac = r_smac;
                        res_fop      = arpc_pkg::FOP_REPLY;
                        res_tmac     = r_smac;
                        res_tip      = r_sip;
                    end else begin
                        res_status   = arpc_pkg::ST_ACCEPTED;
                    end
                end
            end
            arpc_pkg::OP_LOOKUP: begin
                if (r_hit) begin
                    res_status = arpc_pkg::ST_HIT;
                    res_lmac   = r_hit_mac;
                end else begin
                    res_status = arpc_pkg::ST_MISS;
                end
            end
            arpc_pkg::OP_REQUEST: begin
                if (!r_local_ip_valid || (r_tip == '0)) begin
                    res_status = arpc_pkg::ST_REQ_REF;
                end else begin
                    res_status   = arpc_pkg::ST_REQ_SENT;
                    res_dest_mac = arpc_pkg::MAC_BCAST;
                    res_fop      = arpc_pkg::FOP_REQUEST;
                    res_tip      = r_tip;
                end
            end
            default: res_status = arpc_pkg::ST_CLEARED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (out_load) begin
            r_m_data <= {5'b0, res_lmac, res_tip, res_tmac, res_fop, res_dest_mac, res_stored};
            r_m_user <= res_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule : arp_responder_cache

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for arp_responder_cache: directed and random ARP operations on the
// stream input, with each result checked field by field against an in-bench cache model.
// Depends on arpc_pkg for widths, codes and protocol constants; needs only the RTL.

module testbench;

    import arpc_pkg::*;

    localparam int unsigned N_ENTRIES  = CACHE_ENTRIES_DEF;
    // Settling cycles after the last result before the registers are written.
    localparam int unsigned QUIET_CYC  = N_ENTRIES + 8;
    localparam int unsigned IP_POOL_SZ = 24;

    // Input item fields, first field in the lowest bits as on s_axis_tdata.
    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] target_ip;
        logic [31:0] sender_ip;
        logic [47:0] src_mac;
        logic [15:0] arp_opcode;
        logic [7:0]  proto_addr_len;
        logic [7:0]  hw_addr_len;
        logic [15:0] proto_type;
        logic [15:0] hw_type;
        logic [10:0] frame_length;
    } t_arp_fields;

    typedef struct packed {
        t_op         op;
        t_arp_fields f;
    } t_arp_item;

    // Result fields, first field in the lowest bits as on m_axis_tdata.
    typedef struct packed {
        logic [4:0]  pad;
        logic [47:0] lookup_mac;
        logic [31:0] frame_target_ip;
        logic [47:0] frame_target_mac;
        t_fop        frame_opcode;
        logic [47:0] frame_dest_mac;
        logic        cache_stored;
    } t_arp_result;

    typedef struct packed {
        t_status     status;
        t_arp_result data;
    } t_arp_outcome;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    wire logic            s_axis_tready;
    // From bit 0: frame_length, hw_type, proto_type, hw_addr_len, proto_addr_len,
    // arp_opcode, src_mac, sender_ip, target_ip, zeros.
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // From bit 0: operation.
    logic [S_TUSER_W-1:0] s_axis_tuser  = '0;

    wire logic                 m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // From bit 0: cache_stored, frame_dest_mac, frame_opcode, frame_target_mac,
    // frame_target_ip, lookup_mac, zeros.
    wire logic [M_TDATA_W-1:0] m_axis_tdata;
    // From bit 0: status.
    wire logic [M_TUSER_W-1:0] m_axis_tuser;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    wire logic [APB_DW-1:0] prdata;
    wire logic              pready;

    arp_responder_cache uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the configuration registers, updated once each write has landed.
    logic [47:0] cfg_mac      = '0;
    logic [31:0] cfg_ip       = '0;
    bit          cfg_ip_valid = 1'b0;

    // Shadow of the address cache. Address and MAC storage start unknown here, but they are
    // only ever consulted where the valid flag is set.
    bit          cache_valid [N_ENTRIES];
    logic [31:0] cache_ip    [N_ENTRIES];
    logic [47:0] cache_mac   [N_ENTRIES];

    t_arp_item    arp_items_to_send [$];
    t_arp_outcome arp_outcomes_due  [$];
    t_arp_item    item_on_bus;

    logic [31:0] ip_pool [IP_POOL_SZ];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;

    // Works out what the block must answer to one accepted item and advances the cache
    // shadow exactly as the block would.
    function automatic t_arp_outcome arp_engine_outcome(t_arp_item it);
        t_arp_outcome r;
        int           hit_slot;
        int           free_slot;
        bit           pkt_ok;
        r = '0;
        case (it.op)
            OP_RECEIVE: begin
                pkt_ok = cfg_ip_valid
                      && it.f.frame_length >= MIN_LEN
                      && it.f.hw_type == HW_ETHERNET
                      && it.f.proto_type == PROTO_IPV4
                      && it.f.hw_addr_len == HW_LEN
                      && it.f.proto_addr_len == PROTO_LEN
                      && (it.f.arp_opcode == OPC_REQUEST || it.f.arp_opcode == OPC_REPLY)
                      && it.f.src_mac != '0
                      && !it.f.src_mac[MCAST_BIT]
                      && it.f.sender_ip != '0;
                if (!pkt_ok) begin
                    r.status = ST_DROPPED;
                end else begin
                    // An existing entry for the sender wins over the first free one.
                    hit_slot  = -1;
                    free_slot = -1;
                    for (int i = 0; i < N_ENTRIES; i++) begin
                        if (hit_slot < 0 && cache_valid[i] && cache_ip[i] == it.f.sender_ip)
                            hit_slot = i;
                        if (free_slot < 0 && !cache_valid[i])
                            free_slot = i;
                    end
                    if (hit_slot < 0 && free_slot >= 0) begin
                        hit_slot              = free_slot;
                        cache_valid[hit_slot] = 1'b1;
                        cache_ip[hit_slot]    = it.f.sender_ip;
                    end
                    if (hit_slot >= 0)
                        cache_mac[hit_slot] = it.f.src_mac;
                    r.data.cache_stored = (hit_slot >= 0);
                    if (it.f.target_ip == cfg_ip && it.f.arp_opcode == OPC_REQUEST) begin
                        r.status                = ST_REPLIED;
                        r.data.frame_dest_mac   = it.f.src_mac;
                        r.data.frame_opcode     = FOP_REPLY;
                        r.data.frame_target_mac = it.f.src_mac;
                        r.data.frame_target_ip  = it.f.sender_ip;
                    end else begin
                        r.status = ST_ACCEPTED;
                    end
                end
            end
            OP_LOOKUP: begin
                r.status = ST_MISS;
                for (int i = 0; i < N_ENTRIES; i++) begin
                    if (r.status == ST_MISS && cache_valid[i]
                            && cache_ip[i] == it.f.target_ip) begin
                        r.status          = ST_HIT;
                        r.data.lookup_mac = cache_mac[i];
                    end
                end
            end
            OP_REQUEST: begin
                if (!cfg_ip_valid || it.f.target_ip == '0) begin
                    r.status = ST_REQ_REF;
                end else begin
                    r.status               = ST_REQ_SENT;
                    r.data.frame_dest_mac  = MAC_BCAST;
                    r.data.frame_opcode    = FOP_REQUEST;
                    r.data.frame_target_ip = it.f.target_ip;
                end
            end
            default: begin
                for (int i = 0; i < N_ENTRIES; i++)
                    cache_valid[i] = 1'b0;
                r.status = ST_CLEARED;
            end
        endcase
        return r;
    endfunction

    // A packet that passes every check; callers break one field to make a drop case.
    function automatic t_arp_item well_formed_packet(logic [15:0] opcode, logic [47:0] mac,
                                                     logic [31:0] sip, logic [31:0] tip);
        t_arp_item it;
        it                  = '0;
        it.op               = OP_RECEIVE;
        it.f.frame_length   = MIN_LEN;
        it.f.hw_type        = HW_ETHERNET;
        it.f.proto_type     = PROTO_IPV4;
        it.f.hw_addr_len    = HW_LEN;
        it.f.proto_addr_len = PROTO_LEN;
        it.f.arp_opcode     = opcode;
        it.f.src_mac        = mac;
        it.f.sender_ip      = sip;
        it.f.target_ip      = tip;
        return it;
    endfunction

    function automatic t_arp_item address_query(t_op op, logic [31:0] ip);
        t_arp_item it;
        it             = '0;
        it.op          = op;
        it.f.target_ip = ip;
        return it;
    endfunction

    // Random item. Most receives are well-formed with sender addresses from a small pool, so
    // that entries get updated, the cache fills up and full-cache refusals occur; the rest are
    // single broken fields and pure noise.
    function automatic t_arp_item random_arp_item();
        t_arp_item   it;
        t_arp_item   noise;
        logic [47:0] mac;
        int          pick;
        int          sub;
        noise       = '0;
        noise.f     = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        noise.f.pad = '0;
        it          = noise;
        pick        = $urandom_range(99);
        sub         = $urandom_range(9);
        if (pick < 3) begin
            it.op = OP_CLEAR;
        end else if (pick < 28) begin
            it.op = OP_LOOKUP;
            if (sub == 0)
                it.f.target_ip = '0;
            else if (sub < 8)
                it.f.target_ip = ip_pool[$urandom_range(IP_POOL_SZ - 1)];
        end else if (pick < 40) begin
            it.op = OP_REQUEST;
            if (sub == 0)
                it.f.target_ip = '0;
        end else if (sub == 0) begin
            it.op = OP_RECEIVE;
        end else begin
            mac             = {16'($urandom), $urandom};
            mac[MCAST_BIT]  = 1'b0;
            if (mac == '0)
                mac = 48'h1;
            it = well_formed_packet($urandom_range(1) ? OPC_REQUEST : OPC_REPLY, mac,
                                    ip_pool[$urandom_range(IP_POOL_SZ - 1)], noise.f.target_ip);
            it.f.frame_length = 11'($urandom_range(2047, 28));
            if ($urandom_range(9) < 4)
                it.f.target_ip = cfg_ip;
            else if ($urandom_range(1) == 0)
                it.f.target_ip = ip_pool[$urandom_range(IP_POOL_SZ - 1)];
            if (sub == 1) begin
                case ($urandom_range(8))
                    0: it.f.frame_length   = 11'($urandom_range(27));
                    1: it.f.hw_type        = noise.f.hw_type;
                    2: it.f.proto_type     = noise.f.proto_type;
                    3: it.f.hw_addr_len    = noise.f.hw_addr_len;
                    4: it.f.proto_addr_len = noise.f.proto_addr_len;
                    5: it.f.arp_opcode     = noise.f.arp_opcode;
                    6: it.f.src_mac[MCAST_BIT] = 1'b1;
                    7: it.f.src_mac        = '0;
                    default: it.f.sender_ip = '0;
                endcase
            end
        end
        return it;
    endfunction

    // Source side: items leave the queue one by one, with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                arp_outcomes_due.push_back(arp_engine_outcome(item_on_bus));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (arp_items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_on_bus    = arp_items_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item_on_bus.f;
                    s_axis_tuser  <= item_on_bus.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    task automatic check_result(logic [M_TUSER_W-1:0] st, logic [M_TDATA_W-1:0] dat);
        t_arp_outcome want;
        t_arp_result  got;
        got = dat;
        if (arp_outcomes_due.size() == 0) begin
            $display("%0t: result with status %0d arrived with nothing outstanding", $time, st);
            errors++;
        end else begin
            want = arp_outcomes_due.pop_front();
            check_field("status", 64'(want.status), 64'(st));
            check_field("cache_stored", 64'(want.data.cache_stored),
                        64'(got.cache_stored));
            check_field("frame_dest_mac", 64'(want.data.frame_dest_mac),
                        64'(got.frame_dest_mac));
            check_field("frame_opcode", 64'(want.data.frame_opcode),
                        64'(got.frame_opcode));
            check_field("frame_target_mac", 64'(want.data.frame_target_mac),
                        64'(got.frame_target_mac));
            check_field("frame_target_ip", 64'(want.data.frame_target_ip),
                        64'(got.frame_target_ip));
            check_field("lookup_mac", 64'(want.data.lookup_mac), 64'(got.lookup_mac));
            check_field("tdata padding", '0, 64'(got.pad));
        end
    endtask

    // Sink side: results are taken whenever ready is high, and ready stalls at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tuser, m_axis_tdata);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One register write: a setup cycle, then the access cycle at whose closing edge the
    // register takes the data.
    task automatic write_reg(t_reg idx, logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_LOCAL_MAC: cfg_mac      = value[47:0];
            REG_LOCAL_IP:  cfg_ip       = value[31:0];
            default:       cfg_ip_valid = value[0];
        endcase
    endtask

    task automatic set_station(logic [47:0] mac, logic [31:0] ip, bit ip_valid);
        write_reg(REG_LOCAL_MAC, APB_DW'(mac));
        write_reg(REG_LOCAL_IP, APB_DW'(ip));
        write_reg(REG_LOCAL_IP_VALID, APB_DW'(ip_valid));
    endtask

    // Holds off until every queued item has gone in and every result has come out, then waits
    // out the settling time, so that the registers may be written safely. The condition is looked
    // at between clock edges, once the driver has settled.
    task automatic drain_block();
        while (arp_items_to_send.size() != 0 || s_axis_tvalid || arp_outcomes_due.size() != 0)
            @(negedge i_clk);
        repeat (QUIET_CYC) @(posedge i_clk);
    endtask

    task automatic run_random(int n_items, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items) arp_items_to_send.push_back(random_arp_item());
        drain_block();
    endtask

    // A generous bound on the run time of the 435 items.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        t_arp_item   it;
        logic [47:0] mac_a;
        logic [31:0] ip_a;
        logic [31:0] home_ip;
        mac_a   = 48'h02_11_22_33_44_55;
        ip_a    = 32'h0A00_0002;
        home_ip = 32'hC0A8_0001;
        for (int i = 0; i < IP_POOL_SZ; i++) begin
            ip_pool[i] = $urandom;
            if (ip_pool[i] == '0)
                ip_pool[i] = 32'h1;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With the registers still at reset there is no local address: receives drop and
        // requests are refused, and the freshly cleared cache misses.
        arp_items_to_send.push_back(well_formed_packet(OPC_REQUEST, mac_a, ip_a, '0));
        arp_items_to_send.push_back(address_query(OP_REQUEST, ip_a));
        arp_items_to_send.push_back(address_query(OP_LOOKUP, '0));
        drain_block();

        set_station(48'h02_00_00_AB_CD_EF, home_ip, 1'b1);

        // A request for us gives a reply; a reply at the largest length and the highest
        // addresses is only learnt; a later packet from the same sender updates its entry.
        arp_items_to_send.push_back(well_formed_packet(OPC_REQUEST, mac_a, ip_a, home_ip));
        it = well_formed_packet(OPC_REPLY, 48'hFE_FF_FF_FF_FF_FF, 32'hFFFF_FFFF, ip_a);
        it.f.frame_length = 11'd2047;
        arp_items_to_send.push_back(it);
        arp_items_to_send.push_back(well_formed_packet(OPC_REQUEST, mac_a ^ 48'h1, ip_a,
                                                       32'h0A00_0009));
        arp_items_to_send.push_back(address_query(OP_LOOKUP, ip_a));
        arp_items_to_send.push_back(address_query(OP_LOOKUP, 32'hFFFF_FFFF));
        arp_items_to_send.push_back(address_query(OP_LOOKUP, '0));
        arp_items_to_send.push_back(address_query(OP_LOOKUP, 32'h0A00_0003));

        // Each drop condition on its own, one broken field in an otherwise good packet.
        for (int k = 0; k < 11; k++) begin
            it = well_formed_packet(OPC_REPLY, 48'h0A_0B_0C_0D_0E_0F, 32'h0A00_0004, '0);
            case (k)
                0:  it.f.frame_length   = MIN_LEN - 11'd1;
                1:  it.f.hw_type        = '0;
                2:  it.f.proto_type     = 16'h0806;
                3:  it.f.hw_addr_len    = '0;
                4:  it.f.proto_addr_len = 8'hFF;
                5:  it.f.arp_opcode     = '0;
                6:  it.f.arp_opcode     = 16'd3;
                7:  it.f.arp_opcode     = 16'hFFFF;
                8:  it.f.src_mac        = '0;
                9:  it.f.src_mac        = 48'h01_00_00_00_00_00;
                default: it.f.sender_ip = '0;
            endcase
            arp_items_to_send.push_back(it);
        end

        arp_items_to_send.push_back(address_query(OP_REQUEST, '0));
        arp_items_to_send.push_back(address_query(OP_REQUEST, 32'hFFFF_FFFF));
        arp_items_to_send.push_back(address_query(OP_CLEAR, '0));
        arp_items_to_send.push_back(address_query(OP_LOOKUP, ip_a));
        drain_block();

        // Random phases, each under its own station setting and idling pattern. Every phase
        // ends with the source held back until all results are in.
        set_station({16'($urandom), $urandom} & 48'hFEFF_FFFF_FFFF, $urandom, 1'b1);
        run_random(100, 0, 0);
        set_station(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        run_random(100, 55, 0);
        set_station('0, '0, 1'b1);
        run_random(100, 0, 55);
        set_station({16'($urandom), $urandom}, $urandom, 1'b0);
        run_random(30, 7, 7);
        // The local address is also a pooled sender here, so it lands in the cache.
        set_station({16'($urandom), $urandom}, ip_pool[0], 1'b1);
        run_random(80, 7, 7);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
